>>> design/alarm_timer_bank_core_macros.svh
// assertion macros used by the alarm timer bank core
`ifndef ALARM_TIMER_BANK_CORE_MACROS_SVH
`define ALARM_TIMER_BANK_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define ATB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("alarm timer bank assertion failed");

// next-cycle implication, checked out of reset
`define ATB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("alarm timer bank assertion failed");

`endif

>>> design/atb_pkg.sv
// types and constants of the alarm timer bank
`default_nettype none

package atb_pkg;

    localparam int TIMER_SEL_W = 2;
    localparam int REG_SEL_W   = 3;
    localparam int COUNT_W     = 32;
    localparam int MASK_W      = 4;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // register write codes
    localparam logic [REG_SEL_W-1:0] REG_BEGIN = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_ALARM = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_COUNT = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_START = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_STOP  = 3'd4;

    // per-timer control for one transaction
    typedef struct packed {
        logic                        tick;
        logic                        write;
        logic [REG_SEL_W-1:0]        reg_sel;
        logic signed [COUNT_W-1:0]   value;
        logic                        flag;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> design/atb_timer_cell.sv
// one up/down alarm timer with auto-reload
`default_nettype none

module atb_timer_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire atb_pkg::cell_ctl_t ctl,
    output logic                   fire
);
    import atb_pkg::*;

    logic signed [COUNT_W-1:0] count_reg, count_next;
    logic signed [COUNT_W-1:0] alarm_reg, alarm_next;
    logic signed [COUNT_W-1:0] reload_reg, reload_next;
    logic                      enabled_reg, enabled_next;
    logic                      up_reg, up_next;
    logic                      auto_reg, auto_next;

    logic signed [COUNT_W-1:0] count_inc;
    logic signed [COUNT_W-1:0] count_dec;
    logic                      hit_up;
    logic                      hit_down;

    // step and compare, signed with wrap
    assign count_inc = count_reg + COUNT_W'(1);
    assign count_dec = count_reg - COUNT_W'(1);
    assign hit_up    = (count_inc >= alarm_reg);
    assign hit_down  = (count_dec <= $signed(COUNT_W'(0)));
    assign fire      = ctl.tick && enabled_reg && (up_reg ? hit_up : hit_down);

    // next state for a tick or a register write
    always_comb begin
        count_next   = count_reg;
        alarm_next   = alarm_reg;
        reload_next  = reload_reg;
        enabled_next = enabled_reg;
        up_next      = up_reg;
        auto_next    = auto_reg;
        if (ctl.tick && enabled_reg) begin
            if (up_reg) begin
                count_next = hit_up ? '0 : count_inc;
            end else begin
                count_next = hit_down ? reload_reg : count_dec;
            end
            if (fire && !auto_reg) begin
                enabled_next = 1'b0;
            end
        end else if (ctl.write) begin
            case (ctl.reg_sel)
                REG_BEGIN: begin
                    up_next      = ctl.flag;
                    enabled_next = 1'b1;
                end
                REG_ALARM: begin
                    alarm_next = ctl.value;
                    auto_next  = ctl.flag;
                end
                REG_COUNT: begin
                    reload_next = ctl.value;
                    count_next  = up_reg ? '0 : alarm_reg;
                end
                REG_START: begin
                    enabled_next = 1'b1;
                end
                REG_STOP: begin
                    enabled_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            alarm_reg   <= '0;
            reload_reg  <= '0;
            enabled_reg <= 1'b0;
            up_reg      <= 1'b1;
            auto_reg    <= 1'b0;
        end else begin
            count_reg   <= count_next;
            alarm_reg   <= alarm_next;
            reload_reg  <= reload_next;
            enabled_reg <= enabled_next;
            up_reg      <= up_next;
            auto_reg    <= auto_next;
        end
    end

endmodule

`default_nettype wire

>>> design/alarm_timer_bank_core.sv
// Alarm timer bank: NUM_TIMERS up/down timers with alarm and auto-reload.
// Each transaction is a tick (every enabled timer steps by one) or a register
// write to one timer (begin, alarm, count, start, stop). Every transaction
// gives exactly one result, the mask of timers that fired on that tick (zero
// for writes; only timers 0 to 3 show in the mask, and only timers 0 to 3 can
// be addressed). One transaction is taken per clock cycle while m_ready stays
// high. A transaction is first held in the input register, then the timer
// update and mask go into the result register in a single pass, which raises
// m_valid. While a result waits, the input register holds one more transaction
// and s_ready drops until m_ready frees the result register.
`default_nettype none

`include "alarm_timer_bank_core_macros.svh"

module alarm_timer_bank_core #(
    parameter int NUM_TIMERS = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_req_type,
    input  wire logic [atb_pkg::TIMER_SEL_W-1:0]   s_timer_sel,
    input  wire logic [atb_pkg::REG_SEL_W-1:0]     s_reg_sel,
    input  wire logic signed [atb_pkg::COUNT_W-1:0] s_write_value,
    input  wire logic                              s_write_flag,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [atb_pkg::MASK_W-1:0]             m_fire_mask
);
    import atb_pkg::*;

    localparam int ADDR_RANGE = 1 << TIMER_SEL_W;

    logic                      in_valid_reg;
    logic                      in_req_type_reg;
    logic [TIMER_SEL_W-1:0]    in_timer_sel_reg;
    logic [REG_SEL_W-1:0]      in_reg_sel_reg;
    logic signed [COUNT_W-1:0] in_write_value_reg;
    logic                      in_write_flag_reg;

    logic                      m_valid_reg;
    logic [MASK_W-1:0]         m_fire_mask_reg, m_fire_mask_next;

    logic                      advance;
    logic [NUM_TIMERS-1:0]     fire_vec;

    // move the held transaction into the result register when it is free
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_type_reg    <= s_req_type;
            in_timer_sel_reg   <= s_timer_sel;
            in_reg_sel_reg     <= s_reg_sel;
            in_write_value_reg <= s_write_value;
            in_write_flag_reg  <= s_write_flag;
        end
    end

    // timer cells
    for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
        cell_ctl_t ctl;
        logic      hit_sel;

        if (i < ADDR_RANGE) begin : g_addr
            assign hit_sel = (in_timer_sel_reg == TIMER_SEL_W'(i));
        end else begin : g_noaddr
            assign hit_sel = 1'b0;
        end

        assign ctl.tick    = advance && (in_req_type_reg == REQ_TICK);
        assign ctl.write   = advance && (in_req_type_reg == REQ_WRITE) && hit_sel;
        assign ctl.reg_sel = in_reg_sel_reg;
        assign ctl.value   = in_write_value_reg;
        assign ctl.flag    = in_write_flag_reg;

        atb_timer_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .fire    (fire_vec[i])
        );
    end

    // fire mask over the first four timers
    for (genvar j = 0; j < MASK_W; j++) begin : g_mask
        if (j < NUM_TIMERS) begin : g_bit
            assign m_fire_mask_next[j] = fire_vec[j];
        end else begin : g_zero
            assign m_fire_mask_next[j] = 1'b0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_fire_mask_reg <= m_fire_mask_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_fire_mask = m_fire_mask_reg;

    // checks
    `ATB_ASSERT_NXT(a_write_no_fire, aclk, aresetn,
        advance && (in_req_type_reg == REQ_WRITE), m_fire_mask == '0)
    `ATB_ASSERT_IMP(a_stall_only_full, aclk, aresetn, !s_ready, in_valid_reg && m_valid_reg)
    `ATB_ASSERT_IMP(a_result_from_input, aclk, aresetn, $rose(m_valid), $past(advance))

endmodule

`default_nettype wire

>>> sim/alarm_timer_bank_core_tb.sv
// self-checking testbench for the alarm timer bank core
`default_nettype none

// tracks timer state and the fire masks still owed by the block
class alarm_scoreboard #(int TIMERS = 4);
    logic signed [atb_pkg::COUNT_W-1:0] count_q[TIMERS];
    logic signed [atb_pkg::COUNT_W-1:0] alarm_q[TIMERS];
    logic signed [atb_pkg::COUNT_W-1:0] reload_q[TIMERS];
    bit enabled[TIMERS];
    bit upward[TIMERS];
    bit auto_reload[TIMERS];
    logic [atb_pkg::MASK_W-1:0] fire_masks_due[$];
    int errors;

    function new();
        foreach (count_q[i]) begin
            count_q[i]     = '0;
            alarm_q[i]     = '0;
            reload_q[i]    = '0;
            enabled[i]     = 1'b0;
            upward[i]      = 1'b1;
            auto_reload[i] = 1'b0;
        end
        errors = 0;
    endfunction

    function int pending();
        return fire_masks_due.size();
    endfunction

    // apply one accepted transaction and queue the mask it must produce
    function void note_request(logic req_type, logic [atb_pkg::TIMER_SEL_W-1:0] sel,
                               logic [atb_pkg::REG_SEL_W-1:0] rsel,
                               logic signed [atb_pkg::COUNT_W-1:0] value, logic flag);
        logic [atb_pkg::MASK_W-1:0] mask;
        mask = '0;
        if (req_type == atb_pkg::REQ_WRITE) begin
            if (int'(sel) < TIMERS) begin
                case (rsel)
                    atb_pkg::REG_BEGIN: begin
                        upward[sel]  = flag;
                        enabled[sel] = 1'b1;
                    end
                    atb_pkg::REG_ALARM: begin
                        alarm_q[sel]     = value;
                        auto_reload[sel] = flag;
                    end
                    atb_pkg::REG_COUNT: begin
                        reload_q[sel] = value;
                        count_q[sel]  = upward[sel] ? '0 : alarm_q[sel];
                    end
                    atb_pkg::REG_START: enabled[sel] = 1'b1;
                    atb_pkg::REG_STOP:  enabled[sel] = 1'b0;
                    default: ;
                endcase
            end
        end else begin
            // tick: every enabled timer steps once, compares are signed
            for (int i = 0; i < TIMERS; i++) begin
                bit fired;
                fired = 1'b0;
                if (enabled[i]) begin
                    if (upward[i]) begin
                        count_q[i] = count_q[i] + 1;
                        if (count_q[i] >= alarm_q[i]) begin
                            count_q[i] = '0;
                            fired = 1'b1;
                        end
                    end else begin
                        count_q[i] = count_q[i] - 1;
                        if (0 >= count_q[i]) begin
                            count_q[i] = reload_q[i];
                            fired = 1'b1;
                        end
                    end
                    if (fired) begin
                        if (i < atb_pkg::MASK_W)
                            mask[i] = 1'b1;
                        if (!auto_reload[i])
                            enabled[i] = 1'b0;
                    end
                end
            end
        end
        fire_masks_due.push_back(mask);
    endfunction

    // compare one result transaction against the oldest owed mask
    function void check_fire_mask(logic [atb_pkg::MASK_W-1:0] seen);
        logic [atb_pkg::MASK_W-1:0] owed;
        if (fire_masks_due.size() == 0) begin
            $display("%0t: unexpected result, fire_mask actual %h", $time, seen);
            errors++;
        end else begin
            owed = fire_masks_due.pop_front();
            if (seen !== owed) begin
                $display("%0t: fire_mask mismatch, expected %h actual %h", $time, owed, seen);
                errors++;
            end
        end
    endfunction
endclass

module alarm_timer_bank_core_tb;
    import atb_pkg::*;

    localparam int NUM_TIMERS   = 4;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 400;
    localparam logic [REG_SEL_W-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [REG_SEL_W-1:0] REG_UNUSED_LAST  = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = REQ_TICK;
    logic [TIMER_SEL_W-1:0] s_timer_sel = '0;
    logic [REG_SEL_W-1:0] s_reg_sel = '0;
    logic signed [COUNT_W-1:0] s_write_value = '0;
    logic s_write_flag = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [MASK_W-1:0] m_fire_mask;

    alarm_scoreboard #(NUM_TIMERS) sb;
    int items_sent = 0;
    int burst_left = 1;
    bit hold_done = 1'b0;

    alarm_timer_bank_core #(.NUM_TIMERS(NUM_TIMERS)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_timer_sel   (s_timer_sel),
        .s_reg_sel     (s_reg_sel),
        .s_write_value (s_write_value),
        .s_write_flag  (s_write_flag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fire_mask   (m_fire_mask)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // offer one transaction, wait for it to be taken, then maybe pause the burst
    task automatic push_request(logic req_type, logic [TIMER_SEL_W-1:0] sel,
                                logic [REG_SEL_W-1:0] rsel,
                                logic signed [COUNT_W-1:0] value, logic flag);
        int gap;
        s_valid       <= 1'b1;
        s_req_type    <= req_type;
        s_timer_sel   <= sel;
        s_reg_sel     <= rsel;
        s_write_value <= value;
        s_write_flag  <= flag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req_type, sel, rsel, value, flag);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic write_reg(logic [TIMER_SEL_W-1:0] sel, logic [REG_SEL_W-1:0] rsel,
                             logic signed [COUNT_W-1:0] value, logic flag);
        push_request(REQ_WRITE, sel, rsel, value, flag);
    endtask

    // tick with junk in the fields the block ignores
    task automatic tick();
        push_request(REQ_TICK, TIMER_SEL_W'($urandom), REG_SEL_W'($urandom),
                     COUNT_W'($urandom), 1'($urandom));
    endtask

    // mostly small values so alarms are reached, now and then a full-range one
    function automatic logic signed [COUNT_W-1:0] pick_value();
        int v;
        if ($urandom_range(0, 7) == 0)
            return COUNT_W'($urandom);
        v = int'($urandom_range(0, 13)) - 3;
        return COUNT_W'(v);
    endfunction

    // stimulus
    initial begin
        logic [TIMER_SEL_W-1:0] t;
        int choice;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // nothing enabled yet, and unused register codes
        tick();
        for (int r = REG_UNUSED_FIRST; r <= REG_UNUSED_LAST; r++)
            write_reg(TIMER_SEL_W'(r), REG_SEL_W'(r), 32'hFFFF_FFFF, 1'b1);

        // timer 0 counts up to a small alarm with auto-reload
        write_reg(2'd0, REG_ALARM, 32'sd2, 1'b1);
        write_reg(2'd0, REG_BEGIN, '0, 1'b1);
        // timer 1 sits at the top of the range and wraps when switched upward
        write_reg(2'd1, REG_ALARM, 32'h7FFF_FFFF, 1'b0);
        write_reg(2'd1, REG_BEGIN, '0, 1'b0);
        write_reg(2'd1, REG_COUNT, 32'h8000_0000, 1'b0);
        write_reg(2'd1, REG_BEGIN, '0, 1'b1);
        tick();
        // timer 2 counts down from the most negative value and wraps positive
        write_reg(2'd2, REG_ALARM, 32'h8000_0000, 1'b1);
        write_reg(2'd2, REG_BEGIN, '0, 1'b0);
        write_reg(2'd2, REG_COUNT, 32'sd5, 1'b0);
        tick();
        // timer 3 upward with a negative alarm fires on the first tick
        write_reg(2'd3, REG_ALARM, 32'hFFFF_FFFF, 1'b0);
        write_reg(2'd3, REG_BEGIN, '0, 1'b1);
        tick();
        write_reg(2'd0, REG_STOP, '0, 1'b0);
        write_reg(2'd2, REG_STOP, '0, 1'b0);
        write_reg(2'd1, REG_STOP, '0, 1'b0);
        // timer 3 downward from a negative count, then restarted after disabling
        write_reg(2'd3, REG_BEGIN, '0, 1'b0);
        write_reg(2'd3, REG_COUNT, '0, 1'b0);
        tick();
        write_reg(2'd3, REG_START, '0, 1'b0);
        tick();
        write_reg(2'd0, REG_START, '0, 1'b0);
        push_request(REQ_TICK, '1, '1, '1, 1'b1);

        // random part: well-formed timer setups followed by ticks, plus noise
        while (items_sent < 25 + RANDOM_ITEMS) begin
            choice = $urandom_range(0, 9);
            t = TIMER_SEL_W'($urandom);
            if (choice < 7) begin
                write_reg(t, REG_ALARM, pick_value(), 1'($urandom));
                write_reg(t, REG_BEGIN, COUNT_W'($urandom), 1'($urandom));
                write_reg(t, REG_COUNT, pick_value(), 1'($urandom));
                if ($urandom_range(0, 3) == 0)
                    write_reg(t, REG_START, COUNT_W'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 12)) tick();
            end else if (choice < 9) begin
                push_request(REQ_WRITE, TIMER_SEL_W'($urandom), REG_SEL_W'($urandom),
                             COUNT_W'($urandom), 1'($urandom));
                tick();
            end else begin
                write_reg(t, ($urandom_range(0, 1) == 0) ? REG_STOP : REG_START,
                          COUNT_W'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 4)) tick();
            end
        end
        s_valid <= 1'b0;

        // drain and report
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[alarm_timer_bank_core] OK");
        else
            $display("[alarm_timer_bank_core] ERROR");
        $finish;
    end

    // result side: a randomly chosen stall pattern, plus one long hold-off
    initial begin
        int mode;
        int phase;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        mode = 0;
        phase = 0;
        forever begin
            if (!hold_done && items_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (phase % 64 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= phase[0];
                    2: m_ready <= ($urandom_range(0, 9) < 7);
                    default: m_ready <= ($urandom_range(0, 9) < 3);
                endcase
                phase++;
                @(posedge aclk);
            end
        end
    end

    // check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_fire_mask(m_fire_mask);
    end

    // run limit
    initial begin
        #400000;
        $display("[alarm_timer_bank_core] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
